[design/fdhs_pkg.sv]
// Shared types, level tables and result codes for the fan duty hysteresis stepper.
package fdhs_pkg;

    // Field widths
    localparam int MASK_W    = 4;
    localparam int TEMP_W    = 19;
    localparam int SUM_W     = 21;
    localparam int DUTY_W    = 7;
    localparam int ACTION_W  = 3;
    localparam int MAX_LEVELS = 8;
    localparam int LVL_IDX_W = 3;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 16;

    localparam logic [DUTY_W-1:0] FULL_DUTY = 7'd100;

    // Result codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_HOLD  = 3'd0,
        ACT_UP    = 3'd1,
        ACT_DOWN  = 3'd2,
        ACT_FAULT = 3'd3,
        ACT_RESET = 3'd4
    } action_t;

    // One duty level with its thresholds on the summed millicelsius
    typedef struct packed {
        logic [DUTY_W-1:0]       duty;
        logic signed [SUM_W-1:0] down_at;
        logic signed [SUM_W-1:0] up_at;
    } level_t;

    // Front-to-back airflow levels; unused slots are zero
    localparam level_t F2B_LEVELS [MAX_LEVELS] = '{
        '{duty: 7'd32, down_at: 21'sd0,      up_at: 21'sd174000},
        '{duty: 7'd38, down_at: 21'sd170000, up_at: 21'sd182000},
        '{duty: 7'd50, down_at: 21'sd178000, up_at: 21'sd190000},
        '{duty: 7'd63, down_at: 21'sd186000, up_at: 21'sd0},
        '{duty: 7'd0,  down_at: 21'sd0,      up_at: 21'sd0},
        '{duty: 7'd0,  down_at: 21'sd0,      up_at: 21'sd0},
        '{duty: 7'd0,  down_at: 21'sd0,      up_at: 21'sd0},
        '{duty: 7'd0,  down_at: 21'sd0,      up_at: 21'sd0}
    };

    // Back-to-front airflow levels; unused slots are zero
    localparam level_t B2F_LEVELS [MAX_LEVELS] = '{
        '{duty: 7'd32, down_at: 21'sd0,      up_at: 21'sd140000},
        '{duty: 7'd38, down_at: 21'sd135000, up_at: 21'sd150000},
        '{duty: 7'd50, down_at: 21'sd145000, up_at: 21'sd160000},
        '{duty: 7'd69, down_at: 21'sd155000, up_at: 21'sd0},
        '{duty: 7'd0,  down_at: 21'sd0,      up_at: 21'sd0},
        '{duty: 7'd0,  down_at: 21'sd0,      up_at: 21'sd0},
        '{duty: 7'd0,  down_at: 21'sd0,      up_at: 21'sd0},
        '{duty: 7'd0,  down_at: 21'sd0,      up_at: 21'sd0}
    };

endpackage

[design/fan_duty_hysteresis_stepper.sv]
// Fan duty stepper: one management tick in, one duty decision out.
//
//  channel   dir  payload                                        handshake
//  s_axis    in   tdata: failed, present, temp_a/b/c; tuser: f2b  tvalid/tready
//  m_axis    out  tdata: duty_write, duty_percent, action         tvalid/tready
//
//  An item is registered at the input, decided in one pass and registered at the
//  output; one item per cycle sustained while the output is not stalled.
//  The held duty updates as the item moves to the output register.
//  Reset clears both stage valids and sets the held duty to zero (no level).
//  A stalled output holds its item; the input keeps taking items while the
//  input stage is empty or moving forward.
module fan_duty_hysteresis_stepper #(
    parameter int FAN_COUNT   = 4,
    parameter int LEVEL_COUNT = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // fan_failed_mask[3:0], fan_present_mask[7:4], temp_a[26:8],
    // temp_b[45:27], temp_c[64:46], zero pad above
    input  logic [fdhs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // front_to_back[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // duty_write[0], duty_percent[7:1], action[10:8], zero pad above
    output logic [fdhs_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import fdhs_pkg::*;

    // Used level slots, clamped between two and the table size
    localparam int LVL_N = (LEVEL_COUNT < 2) ? 2 :
                           (LEVEL_COUNT > MAX_LEVELS) ? MAX_LEVELS : LEVEL_COUNT;
    localparam logic [LVL_IDX_W-1:0] LAST_IDX = LVL_IDX_W'(LVL_N - 1);
    // Fans beyond the mask width are not observed
    localparam logic [MASK_W-1:0] FAN_MASK = (FAN_COUNT >= MASK_W) ? {MASK_W{1'b1}} :
                                             MASK_W'((1 << FAN_COUNT) - 1);

    // Input stage
    logic                      in_valid_reg;
    logic [MASK_W-1:0]         failed_reg;
    logic [MASK_W-1:0]         present_reg;
    logic                      f2b_reg;
    logic signed [TEMP_W-1:0]  temp_a_reg;
    logic signed [TEMP_W-1:0]  temp_b_reg;
    logic signed [TEMP_W-1:0]  temp_c_reg;

    // State and output stage
    logic [DUTY_W-1:0]         held_duty_reg;
    logic [DUTY_W-1:0]         held_duty_next;
    logic                      out_valid_reg;
    logic                      write_reg;
    logic                      write_next;
    logic [DUTY_W-1:0]         duty_reg;
    action_t                   action_reg;
    action_t                   action_next;

    logic                      s_take;
    logic                      advance;

    // Move the decided item forward when the output is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    // Decide the duty for the item in the input stage
    always_comb
    begin
        level_t                  tab [MAX_LEVELS];
        logic                    found;
        logic [LVL_IDX_W-1:0]    idx;
        logic [LVL_IDX_W-1:0]    idx_up;
        logic [LVL_IDX_W-1:0]    idx_dn;
        logic signed [SUM_W-1:0] sum;
        logic                    fault;

        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            tab[i] = f2b_reg ? F2B_LEVELS[i] : B2F_LEVELS[i];
        end

        // First level that matches the held duty
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < LVL_N; i++)
        begin
            if (!found && tab[i].duty == held_duty_reg)
            begin
                found = 1'b1;
                idx   = LVL_IDX_W'(i);
            end
        end
        idx_up = idx + 1'b1;
        idx_dn = idx - 1'b1;

        sum   = SUM_W'(temp_a_reg) + SUM_W'(temp_b_reg) + SUM_W'(temp_c_reg);
        fault = ((failed_reg & FAN_MASK) != '0) || ((present_reg & FAN_MASK) != FAN_MASK);

        held_duty_next = held_duty_reg;
        write_next     = 1'b0;
        action_next    = ACT_HOLD;
        if (fault)
        begin
            held_duty_next = FULL_DUTY;
            write_next     = 1'b1;
            action_next    = ACT_FAULT;
        end
        else if (!found)
        begin
            held_duty_next = tab[0].duty;
            write_next     = 1'b1;
            action_next    = ACT_RESET;
        end
        else if (idx != LAST_IDX && sum >= tab[idx].up_at)
        begin
            if (tab[idx_up].duty != held_duty_reg)
            begin
                held_duty_next = tab[idx_up].duty;
                write_next     = 1'b1;
                action_next    = ACT_UP;
            end
        end
        else if (idx != '0 && sum <= tab[idx].down_at)
        begin
            if (tab[idx_dn].duty != held_duty_reg)
            begin
                held_duty_next = tab[idx_dn].duty;
                write_next     = 1'b1;
                action_next    = ACT_DOWN;
            end
        end
    end

    // Stage valids and held duty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_duty_reg <= '0;
        end
        else
        begin
            if (s_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                held_duty_reg <= held_duty_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            failed_reg  <= s_axis_tdata[3:0];
            present_reg <= s_axis_tdata[7:4];
            f2b_reg     <= s_axis_tuser;
            temp_a_reg  <= s_axis_tdata[26:8];
            temp_b_reg  <= s_axis_tdata[45:27];
            temp_c_reg  <= s_axis_tdata[64:46];
        end
        if (advance)
        begin
            write_reg  <= write_next;
            duty_reg   <= held_duty_next;
            action_reg <= action_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, action_reg, duty_reg, write_reg};

endmodule

[design/fdhs_checker.sv]
// Port-level checks for the fan duty stepper, bound to its top level.
module fdhs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fdhs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import fdhs_pkg::*;

    logic                    out_write;
    logic [DUTY_W-1:0]       out_duty;
    logic [ACTION_W-1:0]     out_action;

    assign out_write  = m_axis_tdata[0];
    assign out_duty   = m_axis_tdata[7:1];
    assign out_action = m_axis_tdata[10:8];

    // Hold a stalled result item
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // Refuse input items only while a result item waits
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

    // Write flag agrees with the action
    a_write_action: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_write == (out_action != ACT_HOLD)))
        else $error("duty_write disagrees with action");

    // Fault drives full duty
    a_fault_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_action == ACT_FAULT |-> out_duty == FULL_DUTY)
        else $error("fault action without full duty");

    // Full duty is never a table level, so only a fault shows it
    a_full_only_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_duty == FULL_DUTY |-> out_action == ACT_FAULT)
        else $error("full duty outside a fault");

endmodule

bind fan_duty_hysteresis_stepper fdhs_checker u_fdhs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
